/* sv/tcc_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helpers for the text console cursor engine
// no dependencies; used by the controller, datapath and top module by scoped names

package tcc_pkg;

	// screen geometry
	localparam int ROWS    = 25;
	localparam int COLUMNS = 80;
	localparam int CELLS   = ROWS * COLUMNS;

	// field widths
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int LIN_W  = 11;
	localparam int CHAR_W = 8;
	localparam int TAB_W  = 5;

	// store addressing and sweep counter
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);

	// tab remainder unit: one column bit per step
	localparam int TCNT_W = $clog2(COL_W + 1);
	localparam int TIDX_W = $clog2(COL_W);
	localparam int TNXT_W = COL_W + 1;

	// tab width register
	localparam logic [TAB_W-1:0] TAB_RESET = TAB_W'(8);
	localparam logic [TAB_W-1:0] TAB_MAX   = TAB_W'(16);
	localparam logic [TAB_W-1:0] TAB_MIN   = TAB_W'(1);

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_TAB = 1'b0;

	// stream words
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	// control characters
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

	typedef enum logic [2:0] {
		CLS_PRINT,
		CLS_BS,
		CLS_TAB,
		CLS_NL,
		CLS_FF,
		CLS_CR
	} char_cls_t;

	typedef enum logic [2:0] {
		CUR_NONE,
		CUR_BS,
		CUR_CR,
		CUR_NL,
		CUR_HOME,
		CUR_ADV,
		CUR_TAB
	} cur_op_t;

	typedef enum logic [1:0] {
		SW_IDLE,
		SW_START,
		SW_CLEAR,
		SW_SCROLL
	} sweep_op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_TAB,
		ST_SCROLL,
		ST_FF,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic      take_item;
		logic      store_byte;
		logic      tab_start;
		logic      load_out;
		cur_op_t   cur_op;
		sweep_op_t sweep;
	} tcc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic      is_read;
		char_cls_t cls;
		logic      last_row;
		logic      last_col;
		logic      tab_done;
		logic      tab_wrap;
		logic      sweep_done;
		logic      out_free;
	} tcc_status_t;

	function automatic char_cls_t classify(input logic [CHAR_W-1:0] c);
		char_cls_t r;
		unique case (c)
			CH_BACKSPACE: r = CLS_BS;
			CH_TAB:       r = CLS_TAB;
			CH_NEWLINE:   r = CLS_NL;
			CH_FORMFEED:  r = CLS_FF;
			CH_RETURN:    r = CLS_CR;
			default:      r = CLS_PRINT;
		endcase
		return r;
	endfunction

endpackage

/* sv/tcc_ram.sv */
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one registered read port
// no dependencies

module tcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/tcc_datapath.sv */
`timescale 1ns / 1ps
// datapath: cursor, tab remainder unit, store sweep, output register
// depends on tcc_pkg and tcc_ram

module tcc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcc_pkg::tcc_cmd_t             cmd,
	output tcc_pkg::tcc_status_t          sts,
	input  logic                          in_cmd,
	input  logic [tcc_pkg::CHAR_W-1:0]    in_char,
	input  logic [tcc_pkg::ROW_W-1:0]     in_row,
	input  logic [tcc_pkg::COL_W-1:0]     in_col,
	input  logic                          cfg_we,
	input  logic [tcc_pkg::TAB_W-1:0]     cfg_wdata,
	output logic [tcc_pkg::TAB_W-1:0]     tab_cfg,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tcc_pkg::ROW_W-1:0]     out_row,
	output logic [tcc_pkg::COL_W-1:0]     out_col,
	output logic [tcc_pkg::LIN_W-1:0]     out_lin,
	output logic [tcc_pkg::CHAR_W-1:0]    out_cell
);

	logic [tcc_pkg::TAB_W-1:0]  tab_q;
	logic [tcc_pkg::TAB_W-1:0]  tab_eff;
	logic [tcc_pkg::ROW_W-1:0]  cur_row_q, row_d, row_nl;
	logic [tcc_pkg::COL_W-1:0]  cur_col_q, col_d;
	logic                       last_row, last_col;
	logic [tcc_pkg::ADDR_W-1:0] cur_addr;
	logic [tcc_pkg::LIN_W-1:0]  lin_d;

	logic                       item_read_q, item_oor_q;
	logic [tcc_pkg::CHAR_W-1:0] item_char_q;
	logic                       in_oor;
	logic [tcc_pkg::ADDR_W-1:0] in_addr;

	logic [tcc_pkg::TCNT_W-1:0] tab_cnt_q;
	logic [tcc_pkg::TAB_W-1:0]  rem_q;
	logic [tcc_pkg::TIDX_W-1:0] tab_idx;
	logic [tcc_pkg::TAB_W-1:0]  tab_shift;
	logic [tcc_pkg::TNXT_W-1:0] tab_next;
	logic                       tab_wrap;

	logic [tcc_pkg::CNT_W-1:0]  cnt_q;
	logic                       sweeping, sweep_done, sweep_step, scroll_rd, sweep_zero;
	logic                       wv_s1, wz_s1;
	logic [tcc_pkg::ADDR_W-1:0] wa_s1;

	logic                       ram_we, ram_re;
	logic [tcc_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [tcc_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;
	logic [tcc_pkg::CHAR_W-1:0] cell_byte;

	// tab width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q <= tcc_pkg::TAB_RESET;
		end else if (cfg_we) begin
			tab_q <= cfg_wdata;
		end
	end

	assign tab_cfg = tab_q;

	// out-of-range widths act as the nearest legal one
	always_comb begin
		if (tab_q == '0) begin
			tab_eff = tcc_pkg::TAB_MIN;
		end else if (tab_q > tcc_pkg::TAB_MAX) begin
			tab_eff = tcc_pkg::TAB_MAX;
		end else begin
			tab_eff = tab_q;
		end
	end

	// item register
	assign in_oor  = (int'(in_row) >= tcc_pkg::ROWS) || (int'(in_col) >= tcc_pkg::COLUMNS);
	assign in_addr = tcc_pkg::ADDR_W'(int'(in_row) * tcc_pkg::COLUMNS + int'(in_col));

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			item_read_q <= in_cmd;
			item_char_q <= in_char;
			item_oor_q  <= in_oor;
		end
	end

	// tab remainder: restoring column mod width, msb first
	assign tab_idx   = tcc_pkg::TIDX_W'(tab_cnt_q - 1'b1);
	assign tab_shift = {rem_q[tcc_pkg::TAB_W-2:0], cur_col_q[tab_idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_cnt_q <= '0;
		end else if (cmd.tab_start) begin
			tab_cnt_q <= tcc_pkg::TCNT_W'(tcc_pkg::COL_W);
		end else if (tab_cnt_q != '0) begin
			tab_cnt_q <= tab_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tab_start) begin
			rem_q <= '0;
		end else if (tab_cnt_q != '0) begin
			rem_q <= (tab_shift >= tab_eff) ? tab_shift - tab_eff : tab_shift;
		end
	end

	// next stop is column minus remainder plus width
	assign tab_next = {1'b0, cur_col_q} - tcc_pkg::TNXT_W'(rem_q) + tcc_pkg::TNXT_W'(tab_eff);
	assign tab_wrap = int'(tab_next) >= tcc_pkg::COLUMNS;

	// cursor next state
	assign last_row = int'(cur_row_q) == tcc_pkg::ROWS - 1;
	assign last_col = int'(cur_col_q) == tcc_pkg::COLUMNS - 1;
	assign row_nl   = last_row ? cur_row_q : cur_row_q + 1'b1;

	always_comb begin
		row_d = cur_row_q;
		col_d = cur_col_q;
		unique case (cmd.cur_op)
			tcc_pkg::CUR_NONE: begin
			end
			tcc_pkg::CUR_BS: begin
				if (cur_col_q != '0) begin
					col_d = cur_col_q - 1'b1;
				end
			end
			tcc_pkg::CUR_CR: begin
				col_d = '0;
			end
			tcc_pkg::CUR_NL: begin
				row_d = row_nl;
				col_d = '0;
			end
			tcc_pkg::CUR_HOME: begin
				row_d = '0;
				col_d = '0;
			end
			tcc_pkg::CUR_ADV: begin
				if (last_col) begin
					row_d = row_nl;
					col_d = '0;
				end else begin
					col_d = cur_col_q + 1'b1;
				end
			end
			tcc_pkg::CUR_TAB: begin
				if (tab_wrap) begin
					row_d = row_nl;
					col_d = '0;
				end else begin
					col_d = tab_next[tcc_pkg::COL_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else begin
			cur_row_q <= row_d;
			cur_col_q <= col_d;
		end
	end

	assign cur_addr = tcc_pkg::ADDR_W'(int'(cur_row_q) * tcc_pkg::COLUMNS + int'(cur_col_q));
	assign lin_d    = tcc_pkg::LIN_W'(int'(row_d) * tcc_pkg::COLUMNS + int'(col_d));

	// store sweep: clear or scroll, one cell a cycle, each write in the cycle after its read
	assign sweeping   = (cmd.sweep == tcc_pkg::SW_CLEAR) || (cmd.sweep == tcc_pkg::SW_SCROLL);
	assign sweep_done = int'(cnt_q) == tcc_pkg::CELLS;
	assign sweep_step = sweeping && !sweep_done;
	assign scroll_rd  = (cmd.sweep == tcc_pkg::SW_SCROLL)
		&& (int'(cnt_q) < tcc_pkg::CELLS - tcc_pkg::COLUMNS);
	assign sweep_zero = (cmd.sweep == tcc_pkg::SW_CLEAR)
		|| (int'(cnt_q) >= tcc_pkg::CELLS - tcc_pkg::COLUMNS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wv_s1 <= 1'b0;
		end else begin
			wv_s1 <= sweep_step;
			if (cmd.sweep == tcc_pkg::SW_START) begin
				cnt_q <= '0;
			end else if (sweep_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wa_s1 <= tcc_pkg::ADDR_W'(cnt_q);
		wz_s1 <= sweep_zero;
	end

	// store ports
	assign ram_we    = wv_s1 || cmd.store_byte;
	assign ram_waddr = cmd.store_byte ? cur_addr : wa_s1;
	assign ram_wdata = cmd.store_byte ? item_char_q : (wz_s1 ? '0 : ram_rdata);
	assign ram_re    = (cmd.take_item && !in_oor) || scroll_rd;
	assign ram_raddr = scroll_rd
		? tcc_pkg::ADDR_W'(int'(cnt_q) + tcc_pkg::COLUMNS) : in_addr;

	tcc_ram #(
		.WIDTH(tcc_pkg::CHAR_W),
		.DEPTH(tcc_pkg::CELLS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read data holds until the next read, so it serves a waiting result too
	assign cell_byte = (item_read_q && !item_oor_q) ? ram_rdata : '0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_row  <= row_d;
			out_col  <= col_d;
			out_lin  <= lin_d;
			out_cell <= cell_byte;
		end
	end

	// status
	always_comb begin
		sts.is_read    = item_read_q;
		sts.cls        = tcc_pkg::classify(item_char_q);
		sts.last_row   = last_row;
		sts.last_col   = last_col;
		sts.tab_done   = tab_cnt_q == '0;
		sts.tab_wrap   = tab_wrap;
		sts.sweep_done = sweep_done;
		sts.out_free   = !out_valid || out_ready;
	end

endmodule

/* sv/tcc_ctrl.sv */
`timescale 1ns / 1ps
// controller state machine: sequences put, read, tab, scroll and clear
// depends on tcc_pkg

module tcc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tcc_pkg::tcc_status_t sts,
	output tcc_pkg::tcc_cmd_t    cmd
);

	tcc_pkg::state_t state_q, state_d;

	// state register, reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcc_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd.take_item  = 1'b0;
		cmd.store_byte = 1'b0;
		cmd.tab_start  = 1'b0;
		cmd.load_out   = 1'b0;
		cmd.cur_op     = tcc_pkg::CUR_NONE;
		cmd.sweep      = tcc_pkg::SW_IDLE;

		unique case (state_q)
			tcc_pkg::ST_INIT: begin
				cmd.sweep = tcc_pkg::SW_CLEAR;
				if (sts.sweep_done) begin
					state_d = tcc_pkg::ST_IDLE;
				end
			end
			tcc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_item = 1'b1;
					state_d       = tcc_pkg::ST_EXEC;
				end
			end
			tcc_pkg::ST_EXEC: begin
				state_d = sts.out_free ? tcc_pkg::ST_IDLE : tcc_pkg::ST_FINISH;
				if (sts.is_read) begin
					cmd.load_out = sts.out_free;
				end else begin
					unique case (sts.cls)
						tcc_pkg::CLS_PRINT: begin
							cmd.store_byte = 1'b1;
							cmd.cur_op     = tcc_pkg::CUR_ADV;
							if (sts.last_col && sts.last_row) begin
								cmd.sweep = tcc_pkg::SW_START;
								state_d   = tcc_pkg::ST_SCROLL;
							end else begin
								cmd.load_out = sts.out_free;
							end
						end
						tcc_pkg::CLS_NL: begin
							cmd.cur_op = tcc_pkg::CUR_NL;
							if (sts.last_row) begin
								cmd.sweep = tcc_pkg::SW_START;
								state_d   = tcc_pkg::ST_SCROLL;
							end else begin
								cmd.load_out = sts.out_free;
							end
						end
						tcc_pkg::CLS_FF: begin
							cmd.cur_op = tcc_pkg::CUR_HOME;
							cmd.sweep  = tcc_pkg::SW_START;
							state_d    = tcc_pkg::ST_FF;
						end
						tcc_pkg::CLS_BS: begin
							cmd.cur_op   = tcc_pkg::CUR_BS;
							cmd.load_out = sts.out_free;
						end
						tcc_pkg::CLS_CR: begin
							cmd.cur_op   = tcc_pkg::CUR_CR;
							cmd.load_out = sts.out_free;
						end
						tcc_pkg::CLS_TAB: begin
							cmd.tab_start = 1'b1;
							state_d       = tcc_pkg::ST_TAB;
						end
						default: begin
							cmd.load_out = sts.out_free;
						end
					endcase
				end
			end
			tcc_pkg::ST_TAB: begin
				if (sts.tab_done) begin
					cmd.cur_op = tcc_pkg::CUR_TAB;
					if (sts.tab_wrap && sts.last_row) begin
						cmd.sweep = tcc_pkg::SW_START;
						state_d   = tcc_pkg::ST_SCROLL;
					end else if (sts.out_free) begin
						cmd.load_out = 1'b1;
						state_d      = tcc_pkg::ST_IDLE;
					end else begin
						state_d = tcc_pkg::ST_FINISH;
					end
				end
			end
			tcc_pkg::ST_SCROLL: begin
				cmd.sweep = tcc_pkg::SW_SCROLL;
				if (sts.sweep_done) begin
					state_d = tcc_pkg::ST_FINISH;
				end
			end
			tcc_pkg::ST_FF: begin
				cmd.sweep = tcc_pkg::SW_CLEAR;
				if (sts.sweep_done) begin
					state_d = tcc_pkg::ST_FINISH;
				end
			end
			tcc_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = tcc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcc_pkg::ST_IDLE;
			end
		endcase
	end

	// a result is only loaded into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over a pending result");

	// a character write never shares the port with a sweep write
	a_write_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_byte |-> (cmd.sweep != tcc_pkg::SW_CLEAR && cmd.sweep != tcc_pkg::SW_SCROLL))
		else $error("character write during store sweep");

	// tab stop is applied only once the remainder is settled
	a_tab_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cur_op == tcc_pkg::CUR_TAB |-> sts.tab_done)
		else $error("tab applied before remainder done");

	// the reset clearing pass is never re-entered
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != tcc_pkg::ST_INIT |=> state_q != tcc_pkg::ST_INIT)
		else $error("clearing pass re-entered");

endmodule

/* sv/text_console_cursor_engine.sv */
`timescale 1ns / 1ps
// text console cursor engine: 25 x 80 character store with a cursor
// depends on tcc_pkg, tcc_ctrl, tcc_datapath and tcc_ram
//
// usage
//   s_* stream: one word per item; s_tuser is the command (0 put, 1 read).
//   m_* stream: one result word per item with the cursor after the item,
//   its linear position and, for reads, the stored character.
//   apb port: register 0 at byte address 0 is the tab stop width (reset 8).
// sequencing
//   after reset the store is cleared one cell a cycle while s_tready stays
//   low; config writes are taken meanwhile.
//   put of a printable byte, backspace, return, newline off the last row
//   and reads: the exec state loads the result, or the finish state once
//   the output register is free; the next item is accepted back in idle.
//   tab: the result waits in the tab state for the bit-serial column
//   remainder (one bit a cycle); the next item is accepted after it.
//   newline or wrap on the last row and form feed: the result waits for
//   the one-cell-a-cycle pass over the store, then loads in the finish
//   state; a tab that wraps on the last row adds the remainder steps
//   before that pass.
//   an output register holds the result; the next item is accepted while it
//   waits, and the engine holds its following result until m_tready frees it.

module text_console_cursor_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] char_code, [12:8] read_row, [19:13] read_column, [23:20] zero
	input  logic [tcc_pkg::S_TDATA_W-1:0]   s_tdata,
	// [0] cmd
	input  logic                            s_tuser,
	// master stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [4:0] cursor_row, [11:5] cursor_col, [22:12] cursor_linear,
	// [30:23] cell_char, [31] zero
	output logic [tcc_pkg::M_TDATA_W-1:0]   m_tdata,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcc_pkg::PADDR_W-1:0]     paddr,
	input  logic [tcc_pkg::PDATA_W-1:0]     pwdata,
	output logic [tcc_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);

	tcc_pkg::tcc_cmd_t          cmd;
	tcc_pkg::tcc_status_t       sts;
	logic                       cfg_we;
	logic [tcc_pkg::TAB_W-1:0]  tab_cfg;
	logic [tcc_pkg::ROW_W-1:0]  out_row;
	logic [tcc_pkg::COL_W-1:0]  out_col;
	logic [tcc_pkg::LIN_W-1:0]  out_lin;
	logic [tcc_pkg::CHAR_W-1:0] out_cell;

	// register access
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == tcc_pkg::REG_TAB);
	assign prdata = (paddr[2] == tcc_pkg::REG_TAB)
		? tcc_pkg::PDATA_W'(tab_cfg) : '0;

	tcc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tcc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_cmd   (s_tuser),
		.in_char  (s_tdata[7:0]),
		.in_row   (s_tdata[12:8]),
		.in_col   (s_tdata[19:13]),
		.cfg_we   (cfg_we),
		.cfg_wdata(pwdata[tcc_pkg::TAB_W-1:0]),
		.tab_cfg  (tab_cfg),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_row  (out_row),
		.out_col  (out_col),
		.out_lin  (out_lin),
		.out_cell (out_cell)
	);

	// result word
	assign m_tdata = {1'b0, out_cell, out_lin, out_col, out_row};

endmodule
